/* sv/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int COUNT_W = 13;
  localparam int INDEX_W = 12;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Command traveling down the row of bitmap cells.
  // pos: remaining block limit for allocate, remaining bit offset for free.
  typedef struct packed {
    logic                vld;
    cmd_t                cmd;
    logic                done;
    status_t             status;
    logic [COUNT_W-1:0]  pos;
    logic [INDEX_W-1:0]  granted;
  } tok_t;

endpackage

`default_nettype wire

/* sv/bitmap_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit bitmap block allocator with allocate and free commands.
// ----------------------------------------------------------------------------
// One command at a time. A command enters a row of ceil(MAP_BLOCKS/WORD_BITS)
// bitmap cells, one word per cell, and moves one cell per cycle; the lowest
// clear bit below the block count is taken in the first cell that has one,
// a free is served by the cell holding the named bit. A command passes the
// input register, every cell register and the output register from beat to
// result; the next beat is taken only after the result has left the cell row
// and the core is back in idle. While a result waits in the output register
// the next command is accepted, but not while a second result is held behind
// it. The bitmap is cleared at reset.
`default_nettype none

module bitmap_block_allocator_core #(
  parameter int MAP_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [12:0] cfg_wdata,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_cmd,
  input  wire  [11:0] in_block_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_status,
  output logic [11:0] out_granted_index,
  output logic [12:0] out_free_count
);

  localparam int CW = bba_pkg::COUNT_W;
  localparam int IW = bba_pkg::INDEX_W;
  localparam int MAP_WORDS = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam logic [CW-1:0] MAX_C = (MAP_BLOCKS < (1 << CW)) ? CW'(MAP_BLOCKS) : '1;
  localparam logic [CW-1:0] BC_RESET = CW'(4096);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     block_count_r, used_count_r, used_nxt, eff, res_free;
  bba_pkg::tok_t     tok_in_r;
  bba_pkg::tok_t     chain [MAP_WORDS+1];
  bba_pkg::tok_t     tok_x;
  logic              in_beat, out_free, exit_vld;
  logic              out_valid_r;
  bba_pkg::status_t  out_status_r, hold_status_r;
  logic [IW-1:0]     out_granted_r, hold_granted_r;
  logic [CW-1:0]     out_free_r, hold_free_r;

  assign eff      = (block_count_r > MAX_C) ? MAX_C : block_count_r;
  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BC_RESET;
    end else if (cfg_we) begin
      block_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_in_r.vld <= 1'b0;
    end else begin
      tok_in_r.vld <= in_beat;
    end
    if (in_beat) begin
      tok_in_r.cmd     <= bba_pkg::cmd_t'(in_cmd);
      tok_in_r.granted <= '0;
      if (in_cmd == bba_pkg::CMD_FREE) begin
        tok_in_r.done   <= ({1'b0, in_block_index} >= eff);
        tok_in_r.status <= bba_pkg::STAT_BAD;
        tok_in_r.pos    <= {1'b0, in_block_index};
      end else begin
        tok_in_r.done   <= 1'b0;
        tok_in_r.status <= bba_pkg::STAT_FULL;
        tok_in_r.pos    <= eff;
      end
    end
  end

  assign chain[0] = tok_in_r;

  for (genvar k = 0; k < MAP_WORDS; k++) begin : g_cell
    bba_cell #(
      .WORD_BITS (WORD_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  assign tok_x    = chain[MAP_WORDS];
  assign exit_vld = tok_x.vld && (state_r == ST_SCAN);

  always_comb begin
    used_nxt = used_count_r;
    if (exit_vld && tok_x.status == bba_pkg::STAT_OK) begin
      if (tok_x.cmd == bba_pkg::CMD_ALLOC) begin
        used_nxt = used_count_r + 1'b1;
      end else if (used_count_r != '0) begin
        used_nxt = used_count_r - 1'b1;
      end
    end
  end

  assign res_free = (eff > used_nxt) ? (eff - used_nxt) : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (exit_vld) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_nxt;
      if (exit_vld && out_free) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (exit_vld) begin
      if (out_free) begin
        out_status_r  <= tok_x.status;
        out_granted_r <= tok_x.granted;
        out_free_r    <= res_free;
      end else begin
        hold_status_r  <= tok_x.status;
        hold_granted_r <= tok_x.granted;
        hold_free_r    <= res_free;
      end
    end else if (state_r == ST_HOLD && out_free) begin
      out_status_r  <= hold_status_r;
      out_granted_r <= hold_granted_r;
      out_free_r    <= hold_free_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;
  assign out_free_count    = out_free_r;

  a_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_x.vld |-> state_r == ST_SCAN)
    else $error("command left cell row outside scan");

  a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> tok_in_r.vld && state_r == ST_SCAN)
    else $error("accepted beat did not enter cell row");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> out_valid_r)
    else $error("result held while output empty");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != bba_pkg::STAT_OK |-> out_granted_r == '0)
    else $error("index granted on failed command");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_count_r) <= MAP_BLOCKS)
    else $error("used count exceeds map size");

endmodule

`default_nettype wire

/* sv/bba_cell.sv */
// ----------------------------------------------------------------------------
// bba_cell
// One bitmap word of the allocator. Serves the passing command for its word
// and hands the command on to the next cell through its own register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_cell #(
  parameter int WORD_BITS = 32,
  parameter int CELL_IDX  = 0
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire bba_pkg::tok_t tok_i,
  output bba_pkg::tok_t   tok_o
);

  localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int RW = $clog2(WORD_BITS + 1);
  localparam logic [bba_pkg::INDEX_W-1:0] BASE_G =
    bba_pkg::INDEX_W'(CELL_IDX * WORD_BITS);
  localparam logic [bba_pkg::COUNT_W-1:0] WB_C = bba_pkg::COUNT_W'(WORD_BITS);

  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [WORD_BITS-1:0] lim_mask, avail, low_one, sel_mask;
  logic [BW-1:0]        hit;
  logic                 found, pos_big, tgt_set;
  bba_pkg::tok_t        tok_r, tok_nxt;

  assign pos_big = tok_i.pos >= WB_C;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      lim_mask[j] = pos_big || (tok_i.pos[RW-1:0] > RW'(j));
      sel_mask[j] = (tok_i.pos[BW-1:0] == BW'(j));
    end
  end

  assign avail   = ~word_r & lim_mask;
  assign low_one = avail & (~avail + 1'b1);
  assign tgt_set = |(word_r & sel_mask);

  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found = 1'b1;
        hit   = BW'(j);
      end
    end
  end

  always_comb begin
    tok_nxt  = tok_i;
    word_nxt = word_r;
    if (tok_i.vld && !tok_i.done) begin
      if (tok_i.cmd == bba_pkg::CMD_ALLOC) begin
        if (found) begin
          word_nxt        = word_r | low_one;
          tok_nxt.done    = 1'b1;
          tok_nxt.status  = bba_pkg::STAT_OK;
          tok_nxt.granted = BASE_G + bba_pkg::INDEX_W'(hit);
        end else begin
          tok_nxt.pos = pos_big ? (tok_i.pos - WB_C) : '0;
        end
      end else begin
        if (!pos_big) begin
          tok_nxt.done = 1'b1;
          if (tgt_set) begin
            word_nxt       = word_r & ~sel_mask;
            tok_nxt.status = bba_pkg::STAT_OK;
          end
        end else begin
          tok_nxt.pos = tok_i.pos - WB_C;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r    <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      word_r    <= word_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.cmd     <= tok_nxt.cmd;
    tok_r.done    <= tok_nxt.done;
    tok_r.status  <= tok_nxt.status;
    tok_r.pos     <= tok_nxt.pos;
    tok_r.granted <= tok_nxt.granted;
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

/* dv/bitmap_block_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Self-checking bench for the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
// A short table of directed beats covers first allocations, freeing clear and
// out-of-range blocks, saturation of the free count and the block count
// extremes. Random phases follow, each under its own block count, mixing
// allocates with frees of held blocks and of stray indexes. A local bitmap
// model predicts every reply; both channels see random gaps and stalls.
// ----------------------------------------------------------------------------

module bitmap_block_allocator_core_tb;

  localparam int MAP_BLOCKS = 4096;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES     = 10;
  localparam int PHASE_CMDS = 38;

  typedef struct packed {
    bba_pkg::status_t            status;
    logic [bba_pkg::INDEX_W-1:0] granted;
    logic [bba_pkg::COUNT_W-1:0] free_cnt;
  } reply_t;

  typedef struct packed {
    logic                        is_cfg;
    logic [bba_pkg::COUNT_W-1:0] cfg_val;
    bba_pkg::cmd_t               cmd;
    logic [bba_pkg::INDEX_W-1:0] idx;
    logic                        typed;
    reply_t                      want;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [12:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_cmd;
  logic [11:0]        in_block_index;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [11:0]        out_granted_index;
  logic [12:0]        out_free_count;

  // allocator model
  logic [MAP_BLOCKS-1:0]       map_bits;
  int unsigned                 blocks_taken;
  logic [bba_pkg::COUNT_W-1:0] block_limit;

  reply_t      owed_replies[$];
  int unsigned err_count;
  int unsigned cmds_sent;
  int unsigned limit_writes;
  int unsigned replies_by_status[3];
  bit          no_gaps;

  bitmap_block_allocator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_count    (out_free_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string msg);
    if (err_count < 40) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic reply_t apply_command(input bba_pkg::cmd_t cmd,
                                           input logic [bba_pkg::INDEX_W-1:0] idx);
    reply_t      r;
    int unsigned span;
    int unsigned i;
    bit          found;
    span      = (block_limit > MAP_BLOCKS) ? MAP_BLOCKS : block_limit;
    r.status  = bba_pkg::STAT_OK;
    r.granted = '0;
    found     = 1'b0;
    if (cmd == bba_pkg::CMD_ALLOC) begin
      r.status = bba_pkg::STAT_FULL;
      for (i = 0; i < span && !found; i++) begin
        if (!map_bits[i]) begin
          map_bits[i] = 1'b1;
          blocks_taken++;
          r.granted = bba_pkg::INDEX_W'(i);
          r.status  = bba_pkg::STAT_OK;
          found     = 1'b1;
        end
      end
    end else if (idx >= span || !map_bits[idx]) begin
      r.status = bba_pkg::STAT_BAD;
    end else begin
      map_bits[idx] = 1'b0;
      if (blocks_taken > 0) blocks_taken--;
    end
    r.free_cnt = (span > blocks_taken) ? bba_pkg::COUNT_W'(span - blocks_taken) : '0;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  function automatic plan_row_t cmd_row(input bba_pkg::cmd_t cmd,
                                        input logic [bba_pkg::INDEX_W-1:0] idx,
                                        input logic typed, input bba_pkg::status_t st,
                                        input logic [bba_pkg::INDEX_W-1:0] gr,
                                        input logic [bba_pkg::COUNT_W-1:0] fc);
    plan_row_t row;
    row.is_cfg        = 1'b0;
    row.cfg_val       = '0;
    row.cmd           = cmd;
    row.idx           = idx;
    row.typed         = typed;
    row.want.status   = st;
    row.want.granted  = gr;
    row.want.free_cnt = fc;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [bba_pkg::COUNT_W-1:0] v);
    plan_row_t row;
    row         = cmd_row(bba_pkg::CMD_ALLOC, '0, 1'b0, bba_pkg::STAT_OK, '0, '0);
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  // one beat on the command channel; the model steps at acceptance
  task automatic send_command(input bba_pkg::cmd_t cmd,
                              input logic [bba_pkg::INDEX_W-1:0] idx,
                              input logic typed, input reply_t want);
    int unsigned gap;
    reply_t      r;
    gap = no_gaps ? 0 : pick_gap();
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_block_index <= idx;
    do @(posedge clk); while (!in_ready);
    r = apply_command(cmd, idx);
    owed_replies.push_back(typed ? want : r);
    cmds_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_block_limit(input logic [bba_pkg::COUNT_W-1:0] v);
    wait_idle();
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
    block_limit = v;
    limit_writes++;
  endtask

  // result side backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      repeat (pick_gap()) @(negedge clk) out_ready <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(100, 400) : $urandom_range(1, 30))
        @(negedge clk) out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_status < 3) replies_by_status[out_status]++;
      if (owed_replies.size() == 0) begin
        report($sformatf("reply with none owed: status=%0d idx=%0d free=%0d",
                         out_status, out_granted_index, out_free_count));
      end else begin
        want = owed_replies.pop_front();
        if (out_status !== want.status)
          report($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_granted_index !== want.granted)
          report($sformatf("granted_index %0d, want %0d", out_granted_index, want.granted));
        if (out_free_count !== want.free_cnt)
          report($sformatf("free_count %0d, want %0d", out_free_count, want.free_cnt));
      end
    end
  end

  // no handshake for too long ends the run
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("ERROR: no progress for %0d cycles, %0d replies owed",
             IDLE_LIMIT, owed_replies.size());
    $display("bitmap_block_allocator_core_tb: done, errors");
    $finish;
  end

  initial begin
    plan_row_t                   plan[$];
    plan_row_t                   row;
    logic [bba_pkg::INDEX_W-1:0] held[$];
    logic [bba_pkg::INDEX_W-1:0] idx;
    logic [bba_pkg::COUNT_W-1:0] limit_val;
    int unsigned                 span;
    int unsigned                 pick;
    reply_t                      none;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_cmd         = 1'b0;
    in_block_index = '0;
    map_bits       = '0;
    blocks_taken   = 0;
    block_limit    = bba_pkg::COUNT_W'(MAP_BLOCKS);
    err_count      = 0;
    cmds_sent      = 0;
    limit_writes   = 0;
    no_gaps        = 1'b0;
    none           = '0;

    // directed: reset count first, then 1, 0 and all ones, then a tiny map
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 1, bba_pkg::STAT_OK, 12'd0, 13'd4095));
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd4095, 1, bba_pkg::STAT_OK, 12'd1, 13'd4094));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd4095, 1, bba_pkg::STAT_BAD, 12'd0, 13'd4094));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd2, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd0, 1, bba_pkg::STAT_OK, 12'd0, 13'd4095));
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 1, bba_pkg::STAT_OK, 12'd0, 13'd4094));
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd1, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd1, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cfg_row(13'd1));
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 1, bba_pkg::STAT_FULL, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd2, 1, bba_pkg::STAT_BAD, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd0, 1, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 1, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cfg_row(13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 1, bba_pkg::STAT_FULL, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd0, 1, bba_pkg::STAT_BAD, 12'd0, 13'd0));
    plan.push_back(cfg_row(13'd8191));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd2, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd0, 1, bba_pkg::STAT_OK, 12'd0, 13'd4096));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd4095, 1, bba_pkg::STAT_BAD, 12'd0, 13'd4096));
    plan.push_back(cfg_row(13'd3));
    repeat (4)
      plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_FREE, 12'd1, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));
    plan.push_back(cmd_row(bba_pkg::CMD_ALLOC, 12'd0, 0, bba_pkg::STAT_OK, 12'd0, 13'd0));

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (plan[k]) begin
      row = plan[k];
      if (row.is_cfg) set_block_limit(row.cfg_val);
      else send_command(row.cmd, row.idx, row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       limit_val = 13'd0;
        1:       limit_val = 13'd1;
        2:       limit_val = 13'd4096;
        3:       limit_val = bba_pkg::COUNT_W'($urandom_range(4097, 8191));
        4:       limit_val = bba_pkg::COUNT_W'($urandom_range(49, 600));
        default: limit_val = bba_pkg::COUNT_W'($urandom_range(2, 48));
      endcase
      if (p == 0) limit_val = 13'd4096;
      set_block_limit(limit_val);
      no_gaps = ($urandom_range(0, 3) == 0);
      span = (limit_val > MAP_BLOCKS) ? MAP_BLOCKS : limit_val;
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if (p == 4 && n == PHASE_CMDS / 2) wait_idle();
        pick = $urandom_range(0, 99);
        idx  = bba_pkg::INDEX_W'($urandom);
        if (pick < 50) begin
          send_command(bba_pkg::CMD_ALLOC, idx, 1'b0, none);
        end else begin
          if (pick < 85) begin
            held.delete();
            for (int b = 0; b < MAP_BLOCKS; b++)
              if (map_bits[b]) held.push_back(bba_pkg::INDEX_W'(b));
            if (held.size() != 0) idx = held[$urandom_range(0, held.size() - 1)];
          end else if (pick < 95) begin
            idx = bba_pkg::INDEX_W'($urandom_range(0, (span + 4 > MAP_BLOCKS - 1) ?
                                                      MAP_BLOCKS - 1 : span + 4));
          end
          send_command(bba_pkg::CMD_FREE, idx, 1'b0, none);
        end
      end
    end

    wait_idle();
    repeat (150) @(posedge clk);

    $display("covered %0d commands over %0d block count settings, extremes included",
             cmds_sent, limit_writes);
    $display("replies seen: %0d ok, %0d full, %0d bad index, %0d mismatches",
             replies_by_status[0], replies_by_status[1], replies_by_status[2], err_count);
    if (err_count == 0) begin
      $display("bitmap_block_allocator_core_tb: done, clean");
    end else begin
      $display("bitmap_block_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
